FILE: src/wlc_pkg.sv
package wlc_pkg;

  localparam int SEGMENT_COUNT_DEF = 10;

  localparam int LED_W   = 10;
  localparam int LEVEL_W = 4;
  localparam int CNT_W   = 16;
  localparam int DEB_W   = 10;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_DECIDE   = 2'd1,
    CFG_STEP     = 2'd2,
    CFG_LOCKOUT  = 2'd3
  } cfg_idx_t;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(10);
  localparam logic [CNT_W-1:0] DECIDE_RST   = CNT_W'(500);
  localparam logic [CNT_W-1:0] STEP_RST     = CNT_W'(400);
  localparam logic [CNT_W-1:0] LOCKOUT_RST  = CNT_W'(5000);

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'd0,
    MODE_DEB_UP    = 4'd1,
    MODE_DEB_DOWN  = 4'd2,
    MODE_DEC_UP    = 4'd3,
    MODE_DEC_DOWN  = 4'd4,
    MODE_MAN_UP    = 4'd5,
    MODE_AUTO_UP   = 4'd6,
    MODE_MAN_DOWN  = 4'd7,
    MODE_AUTO_DOWN = 4'd8,
    MODE_PINCH     = 4'd9,
    MODE_LOCK      = 4'd10
  } mode_t;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] decide_ticks;
    logic [CNT_W-1:0] step_ticks;
    logic [CNT_W-1:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [LED_W-1:0]   segment_leds;
    logic               up_indicator;
    logic               down_indicator;
    logic [LEVEL_W-1:0] window_level;
    logic               locked_out;
  } res_t;

endpackage

FILE: src/wlc_fsm.sv
module wlc_fsm #(
  parameter int SEGMENT_COUNT = wlc_pkg::SEGMENT_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step_en,
  input  logic          up,
  input  logic          down,
  input  logic          pinch,
  input  wlc_pkg::cfg_t cfg,
  output wlc_pkg::res_t res
);
  import wlc_pkg::*;

  localparam int LW = $clog2(SEGMENT_COUNT + 1);
  localparam logic [LW-1:0] LEVEL_MAX = LW'(SEGMENT_COUNT);

  mode_t           mode, mode_next;
  logic [LW-1:0]   level, level_next;
  logic [CNT_W-1:0] tick_count, tick_count_next;

  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] limit;
  logic             done;
  logic             deb_first;
  logic [LW-1:0]    lvl_up, lvl_dn;
  logic [31:0]      lvl_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      level      <= '0;
      tick_count <= '0;
    end else if (step_en) begin
      mode       <= mode_next;
      level      <= level_next;
      tick_count <= tick_count_next;
    end
  end

  // saturating tick count, compared against the timer of the current mode
  assign cnt_inc = (tick_count != '1) ? tick_count + CNT_W'(1) : tick_count;

  always_comb begin
    unique case (mode)
      MODE_DEB_UP, MODE_DEB_DOWN:   limit = CNT_W'(cfg.debounce_ticks);
      MODE_DEC_UP, MODE_DEC_DOWN:   limit = cfg.decide_ticks;
      MODE_LOCK:                    limit = cfg.lockout_ticks;
      default:                      limit = cfg.step_ticks;
    endcase
  end

  assign done      = (cnt_inc >= limit);
  // first tick of a debounce already satisfies a threshold of 0 or 1
  assign deb_first = (cfg.debounce_ticks <= DEB_W'(1));
  assign lvl_up    = (level < LEVEL_MAX) ? level + LW'(1) : level;
  assign lvl_dn    = (level != '0) ? level - LW'(1) : level;

  always_comb begin
    mode_next       = mode;
    level_next      = level;
    tick_count_next = cnt_inc;
    unique case (mode)
      MODE_DEB_UP, MODE_DEB_DOWN: begin
        if ((mode == MODE_DEB_UP) ? !up : !down) begin
          mode_next       = MODE_IDLE;
          tick_count_next = '0;
        end else if (done) begin
          mode_next       = (mode == MODE_DEB_UP) ? MODE_DEC_UP : MODE_DEC_DOWN;
          tick_count_next = '0;
        end
      end
      MODE_DEC_UP: begin
        if (done) begin
          mode_next       = (up && !down) ? MODE_MAN_UP : MODE_AUTO_UP;
          tick_count_next = '0;
        end
      end
      MODE_DEC_DOWN: begin
        if (done) begin
          mode_next       = (down && !up) ? MODE_MAN_DOWN : MODE_AUTO_DOWN;
          tick_count_next = '0;
        end
      end
      MODE_MAN_UP, MODE_AUTO_UP: begin
        if (pinch) begin
          mode_next       = MODE_PINCH;
          tick_count_next = '0;
        end else if (done) begin
          level_next      = lvl_up;
          tick_count_next = '0;
          if (!(((mode == MODE_MAN_UP) ? (up && !down) : !down) && (lvl_up < LEVEL_MAX)))
            mode_next = MODE_IDLE;
        end
      end
      MODE_MAN_DOWN, MODE_AUTO_DOWN: begin
        if (done) begin
          level_next      = lvl_dn;
          tick_count_next = '0;
          if (!(((mode == MODE_MAN_DOWN) ? (down && !up) : !up) && (lvl_dn != '0)))
            mode_next = MODE_IDLE;
        end
      end
      MODE_PINCH: begin
        if (level == '0) begin
          mode_next       = MODE_LOCK;
          tick_count_next = '0;
        end else if (done) begin
          level_next      = lvl_dn;
          tick_count_next = '0;
          if (lvl_dn == '0)
            mode_next = MODE_LOCK;
        end
      end
      MODE_LOCK: begin
        if (done) begin
          mode_next       = MODE_IDLE;
          tick_count_next = '0;
        end
      end
      default: begin
        // idle, and any code without meaning; down wins when both are held
        mode_next       = MODE_IDLE;
        tick_count_next = '0;
        if (down || up) begin
          if (deb_first) begin
            mode_next = down ? MODE_DEC_DOWN : MODE_DEC_UP;
          end else begin
            mode_next       = down ? MODE_DEB_DOWN : MODE_DEB_UP;
            tick_count_next = CNT_W'(1);
          end
        end
      end
    endcase
  end

  // result shows the state after this tick
  assign lvl_ext = 32'(level_next);

  always_comb begin
    for (int i = 0; i < LED_W; i++)
      res.segment_leds[i] = (lvl_ext > 32'(i));
    res.up_indicator   = (mode_next == MODE_MAN_UP) || (mode_next == MODE_AUTO_UP);
    res.down_indicator = (mode_next == MODE_MAN_DOWN) || (mode_next == MODE_AUTO_DOWN) ||
                         (mode_next == MODE_PINCH);
    res.window_level   = lvl_ext[LEVEL_W-1:0];
    res.locked_out     = (mode_next == MODE_LOCK);
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_MAX)
    else $error("window level beyond travel");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(level) && $stable(tick_count) && $stable(mode))
    else $error("state moved without a transfer");

  a_pinch_reopen: assert property (@(posedge clk) disable iff (rst)
    step_en && pinch && (mode == MODE_MAN_UP || mode == MODE_AUTO_UP)
    |=> mode == MODE_PINCH)
    else $error("pinch while closing did not start reopen");

  a_level_step: assert property (@(posedge clk) disable iff (rst)
    step_en |=> (level == $past(level)) || (level == $past(level) + LW'(1)) ||
                (level == $past(level) - LW'(1)))
    else $error("level moved more than one segment");

  a_pinch_lock: assert property (@(posedge clk) disable iff (rst)
    step_en && mode == MODE_PINCH && level == '0 |=> mode == MODE_LOCK)
    else $error("open window in reopen did not lock out");

endmodule

FILE: src/wlc_skid.sv
module wlc_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  wlc_pkg::res_t push_data,
  output logic          pop_valid,
  input  logic          pop_stall,
  output wlc_pkg::res_t pop_data
);
  import wlc_pkg::*;

  res_t       head, skid;
  logic [1:0] count;
  logic       push, pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = head;
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop)
        count <= count + 2'd1;
      else if (pop && !push)
        count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0)
        head <= push_data;
      else
        skid <= push_data;
    end else if (pop && !push) begin
      head <= skid;
    end else if (push && pop) begin
      // count is 1 here: head drains as the new result takes its place
      head <= push_data;
    end
  end

endmodule

FILE: src/window_lifter_controller.sv
// Power window controller with anti-pinch reopen and lockout. Each input
// transfer is one time tick carrying the up, down and pinch inputs, and it
// yields exactly one result: segment bar, direction indicators, level and
// lockout flag, showing the state after that tick. One tick is taken every
// clock cycle while in_stall is low; the result is offered from an
// output register backed by a one-entry skid register, so input stalls only
// when two results are waiting downstream. Timer thresholds are written
// through cfg_we/cfg_index/cfg_data (0 debounce, 1 decide, 2 step, 3 lockout)
// while no tick is in flight; a threshold of zero acts as one.
module window_lifter_controller #(
  parameter int SEGMENT_COUNT = wlc_pkg::SEGMENT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           up_pressed,
  input  logic                           down_pressed,
  input  logic                           pinch_detected,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wlc_pkg::LED_W-1:0]      segment_leds,
  output logic                           up_indicator,
  output logic                           down_indicator,
  output logic [wlc_pkg::LEVEL_W-1:0]    window_level,
  output logic                           locked_out,
  input  logic                           cfg_we,
  input  logic [wlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlc_pkg::CFG_W-1:0]      cfg_data
);
  import wlc_pkg::*;

  cfg_t cfg;
  res_t res, res_out;
  logic step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RST;
      cfg.decide_ticks   <= DECIDE_RST;
      cfg.step_ticks     <= STEP_RST;
      cfg.lockout_ticks  <= LOCKOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: cfg.debounce_ticks <= cfg_data[DEB_W-1:0];
        CFG_DECIDE:   cfg.decide_ticks   <= cfg_data;
        CFG_STEP:     cfg.step_ticks     <= cfg_data;
        CFG_LOCKOUT:  cfg.lockout_ticks  <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign step_en = in_valid && !in_stall;

  wlc_fsm #(
    .SEGMENT_COUNT(SEGMENT_COUNT)
  ) u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step_en(step_en),
    .up     (up_pressed),
    .down   (down_pressed),
    .pinch  (pinch_detected),
    .cfg    (cfg),
    .res    (res)
  );

  wlc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push_valid(in_valid),
    .push_stall(in_stall),
    .push_data (res),
    .pop_valid (out_valid),
    .pop_stall (out_stall),
    .pop_data  (res_out)
  );

  assign segment_leds   = res_out.segment_leds;
  assign up_indicator   = res_out.up_indicator;
  assign down_indicator = res_out.down_indicator;
  assign window_level   = res_out.window_level;
  assign locked_out     = res_out.locked_out;

endmodule
